### sv/rtc_pkg.sv
// Shared types and constants of the route transposition cipher unit.
`default_nettype none

package rtc_pkg;

    localparam int MAX_LEN   = 1024;
    localparam int COL_LIMIT = 50;
    localparam int SYM_W     = 16;
    localparam int COL_W     = 6;
    localparam int ADDR_W    = $clog2(MAX_LEN);
    localparam int CNT_W     = $clog2(MAX_LEN + 1);
    localparam int POS_W     = $clog2(MAX_LEN + COL_LIMIT);
    localparam int DIV_CNT_W = $clog2(POS_W + 1);
    localparam int IDX_W     = 1;

    localparam logic [SYM_W-1:0] PAD_SYMBOL = 16'h0058;

    localparam logic [IDX_W-1:0] CFG_COLUMNS = 1'b0;
    localparam logic [IDX_W-1:0] CFG_MODE    = 1'b1;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_FETCH = 1'b1;

    localparam logic MODE_ENCRYPT = 1'b0;
    localparam logic MODE_DECRYPT = 1'b1;

    typedef struct packed {
        logic             req_type;
        logic [SYM_W-1:0] symbol_in;
        logic             last_in;
    } rtc_req_t;

    typedef struct packed {
        logic [SYM_W-1:0] symbol_out;
        logic             last_out;
        logic             done_res;
        logic             overflow;
    } rtc_res_t;

endpackage

`default_nettype wire

### sv/rtc_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none

module rtc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### sv/route_transposition_cipher_unit.sv
// Load: one item per cycle while idle; the closing load adds a restoring division (ST_DIV),
// the setup states ST_MUL and ST_INIT and, in decrypt, a scan that drops trailing X symbols.
// Fetch: the result is registered from ST_FETCH, which waits while the output stalls; no
// new request is taken until that result is registered.
// Reset clears the control state only; datapath registers and store contents stay undefined
// until written.
`default_nettype none

module route_transposition_cipher_unit (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      req_valid,
    output logic                           req_stall,
    input  wire rtc_pkg::rtc_req_t         req,
    output logic                           res_valid,
    input  wire logic                      res_stall,
    output rtc_pkg::rtc_res_t              res,
    input  wire logic                      wr_en,
    input  wire logic [rtc_pkg::IDX_W-1:0] wr_index,
    input  wire logic [rtc_pkg::COL_W-1:0] wr_data
);

    import rtc_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_DIV      = 7'b0000010,
        ST_MUL      = 7'b0000100,
        ST_INIT     = 7'b0001000,
        ST_SCAN_RD  = 7'b0010000,
        ST_SCAN_CHK = 7'b0100000,
        ST_FETCH    = 7'b1000000
    } state_t;

    state_t               state_reg, state_next;
    logic                 closed_reg, closed_next;
    logic [CNT_W-1:0]     loaded_reg, loaded_next;
    logic                 ovf_reg, ovf_next;
    logic [POS_W-1:0]     idx_reg, idx_next;
    logic [POS_W-1:0]     len_reg, len_next;
    logic [COL_W-1:0]     columns_reg, columns_next;
    logic                 mode_reg, mode_next;
    logic [COL_W-1:0]     key_cols_reg, key_cols_next;
    logic                 key_mode_reg, key_mode_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic                 res_valid_reg, res_valid_next;

    logic [POS_W-1:0]     dvd_reg, dvd_next;
    logic [COL_W-1:0]     rem_reg, rem_next;
    logic [POS_W-1:0]     rows_reg, rows_next;
    logic [POS_W-1:0]     total_reg, total_next;
    logic [POS_W-1:0]     base_reg, base_next;
    logic [POS_W-1:0]     row_i_reg, row_i_next;
    logic [COL_W-1:0]     col_j_reg, col_j_next;
    logic [POS_W-1:0]     addr_reg, addr_next;
    rtc_res_t             res_reg, res_next;

    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr;
    logic                 ram_re;
    logic [SYM_W-1:0]     ram_rdata;

    logic                 req_fire;
    logic                 res_free;
    logic [CNT_W-1:0]     eff_loaded;
    logic [COL_W-1:0]     cols_clamped;
    logic [COL_W:0]       rem_shift;
    logic                 q_bit;
    logic [POS_W+COL_W-1:0] product;
    logic [POS_W-1:0]     cols_ext;
    logic                 addr_pad;
    logic                 fetch_done;

    assign req_fire  = req_valid && !req_stall;
    assign req_stall = (state_reg != ST_IDLE);
    assign res_free  = !res_valid_reg || !res_stall;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    assign eff_loaded = closed_reg ? '0 : loaded_reg;
    assign cols_ext   = POS_W'(key_cols_reg);
    assign addr_pad   = (addr_reg >= POS_W'(loaded_reg));
    assign fetch_done = !closed_reg || (idx_reg >= len_reg);
    assign rem_shift  = {rem_reg, dvd_reg[POS_W-1]};
    assign q_bit      = (rem_shift >= {1'b0, key_cols_reg});
    assign product    = (POS_W+COL_W)'(dvd_reg) * (POS_W+COL_W)'(key_cols_reg);

    always_comb
    begin
        if (columns_reg == '0)
        begin
            cols_clamped = COL_W'(1);
        end
        else if (columns_reg > COL_W'(COL_LIMIT))
        begin
            cols_clamped = COL_W'(COL_LIMIT);
        end
        else
        begin
            cols_clamped = columns_reg;
        end
    end

    rtc_ram #(
        .WIDTH (SYM_W),
        .DEPTH (MAX_LEN)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (req.symbol_in),
        .re    (ram_re),
        .raddr (addr_reg[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        closed_next    = closed_reg;
        loaded_next    = loaded_reg;
        ovf_next       = ovf_reg;
        idx_next       = idx_reg;
        len_next       = len_reg;
        columns_next   = columns_reg;
        mode_next      = mode_reg;
        key_cols_next  = key_cols_reg;
        key_mode_next  = key_mode_reg;
        div_cnt_next   = div_cnt_reg;
        res_valid_next = res_valid_reg && res_stall;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        rows_next      = rows_reg;
        total_next     = total_reg;
        base_next      = base_reg;
        row_i_next     = row_i_reg;
        col_j_next     = col_j_reg;
        addr_next      = addr_reg;
        res_next       = res_reg;
        ram_we         = 1'b0;
        ram_waddr      = eff_loaded[ADDR_W-1:0];
        ram_re         = 1'b0;

        if (wr_en)
        begin
            case (wr_index)
                CFG_COLUMNS: columns_next = wr_data;
                CFG_MODE:    mode_next    = wr_data[0];
                default:     ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire && req.req_type == REQ_LOAD)
                begin
                    // first load after a closed message starts a new one
                    closed_next = 1'b0;
                    ovf_next    = closed_reg ? 1'b0 : ovf_reg;
                    loaded_next = eff_loaded;
                    if (eff_loaded < CNT_W'(MAX_LEN))
                    begin
                        ram_we      = 1'b1;
                        loaded_next = eff_loaded + CNT_W'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (req.last_in)
                    begin
                        key_cols_next = cols_clamped;
                        key_mode_next = mode_reg;
                        dvd_next      = POS_W'(loaded_next) + POS_W'(cols_clamped)
                                        - POS_W'(1);
                        rem_next      = '0;
                        div_cnt_next  = '0;
                        state_next    = ST_DIV;
                    end
                end
                else if (req_fire)
                begin
                    ram_re     = 1'b1;
                    state_next = ST_FETCH;
                end
            end

            ST_DIV:
            begin
                // one quotient bit per cycle: rows = ceil(length / columns)
                rem_next = q_bit ? COL_W'(rem_shift - {1'b0, key_cols_reg})
                                 : rem_shift[COL_W-1:0];
                dvd_next = {dvd_reg[POS_W-2:0], q_bit};
                div_cnt_next = div_cnt_reg + DIV_CNT_W'(1);
                if (div_cnt_reg == DIV_CNT_W'(POS_W - 1))
                begin
                    state_next = ST_MUL;
                end
            end

            ST_MUL:
            begin
                rows_next  = dvd_reg;
                total_next = product[POS_W-1:0];
                state_next = ST_INIT;
            end

            ST_INIT:
            begin
                base_next = total_reg - rows_reg;
                len_next  = total_reg;
                idx_next  = '0;
                if (key_mode_reg == MODE_ENCRYPT)
                begin
                    // start at the top of the rightmost column
                    row_i_next  = '0;
                    col_j_next  = key_cols_reg - COL_W'(1);
                    addr_next   = cols_ext - POS_W'(1);
                    closed_next = 1'b1;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    // walk back from the last output position
                    row_i_next = rows_reg - POS_W'(1);
                    col_j_next = key_cols_reg - COL_W'(1);
                    addr_next  = rows_reg - POS_W'(1);
                    state_next = ST_SCAN_RD;
                end
            end

            ST_SCAN_RD, ST_SCAN_CHK:
            begin
                if (len_reg == '0 || (state_reg == ST_SCAN_CHK && ram_rdata != PAD_SYMBOL))
                begin
                    row_i_next  = '0;
                    col_j_next  = '0;
                    addr_next   = base_reg;
                    closed_next = 1'b1;
                    state_next  = ST_IDLE;
                end
                else if (state_reg == ST_SCAN_RD && !addr_pad)
                begin
                    ram_re     = 1'b1;
                    state_next = ST_SCAN_CHK;
                end
                else
                begin
                    // trailing X: drop it and step back one position
                    len_next   = len_reg - POS_W'(1);
                    state_next = ST_SCAN_RD;
                    if (col_j_reg == '0)
                    begin
                        col_j_next = key_cols_reg - COL_W'(1);
                        row_i_next = row_i_reg - POS_W'(1);
                        addr_next  = row_i_reg - POS_W'(1);
                    end
                    else
                    begin
                        col_j_next = col_j_reg - COL_W'(1);
                        addr_next  = addr_reg + rows_reg;
                    end
                end
            end

            ST_FETCH:
            begin
                if (res_free)
                begin
                    res_valid_next = 1'b1;
                    res_next.overflow = ovf_reg;
                    state_next = ST_IDLE;
                    if (fetch_done)
                    begin
                        res_next.symbol_out = '0;
                        res_next.last_out   = 1'b0;
                        res_next.done_res   = 1'b1;
                    end
                    else
                    begin
                        res_next.symbol_out = addr_pad ? PAD_SYMBOL : ram_rdata;
                        res_next.last_out   = (idx_reg + POS_W'(1) == len_reg);
                        res_next.done_res   = 1'b0;
                        idx_next = idx_reg + POS_W'(1);
                        if (key_mode_reg == MODE_ENCRYPT)
                        begin
                            if (row_i_reg == rows_reg - POS_W'(1))
                            begin
                                row_i_next = '0;
                                col_j_next = col_j_reg - COL_W'(1);
                                addr_next  = POS_W'(col_j_reg) - POS_W'(1);
                            end
                            else
                            begin
                                row_i_next = row_i_reg + POS_W'(1);
                                addr_next  = addr_reg + cols_ext;
                            end
                        end
                        else
                        begin
                            if (col_j_reg == key_cols_reg - COL_W'(1))
                            begin
                                col_j_next = '0;
                                row_i_next = row_i_reg + POS_W'(1);
                                addr_next  = base_reg + row_i_reg + POS_W'(1);
                            end
                            else
                            begin
                                col_j_next = col_j_reg + COL_W'(1);
                                addr_next  = addr_reg - rows_reg;
                            end
                        end
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            closed_reg    <= 1'b0;
            loaded_reg    <= '0;
            ovf_reg       <= 1'b0;
            idx_reg       <= '0;
            len_reg       <= '0;
            columns_reg   <= COL_W'(1);
            mode_reg      <= MODE_ENCRYPT;
            key_cols_reg  <= COL_W'(1);
            key_mode_reg  <= MODE_ENCRYPT;
            div_cnt_reg   <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            closed_reg    <= closed_next;
            loaded_reg    <= loaded_next;
            ovf_reg       <= ovf_next;
            idx_reg       <= idx_next;
            len_reg       <= len_next;
            columns_reg   <= columns_next;
            mode_reg      <= mode_next;
            key_cols_reg  <= key_cols_next;
            key_mode_reg  <= key_mode_next;
            div_cnt_reg   <= div_cnt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg   <= dvd_next;
        rem_reg   <= rem_next;
        rows_reg  <= rows_next;
        total_reg <= total_next;
        base_reg  <= base_next;
        row_i_reg <= row_i_next;
        col_j_reg <= col_j_next;
        addr_reg  <= addr_next;
        res_reg   <= res_next;
    end

endmodule

`default_nettype wire

### tb/sv/route_transposition_cipher_unit_tb.sv
// Self-checking testbench for the route transposition cipher unit.
`timescale 1ns / 100ps

module route_transposition_cipher_unit_tb;

    import rtc_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int PHASE_ITEMS   = 30;
    localparam int OVF_FETCHES   = 4;
    localparam int DRAIN_CYCLES  = 24;
    localparam int SCRIPT_LEN    = 32;
    localparam int REPORT_LIMIT  = 10;

    typedef enum logic [1:0] {ROW_LOAD, ROW_FETCH, ROW_SET_COLS, ROW_SET_MODE} script_op_t;

    typedef struct {
        script_op_t       op;
        logic [SYM_W-1:0] value;
        logic             last;
        bit               typed;
        rtc_res_t         want;
    } script_row_t;

    localparam rtc_res_t OUT_DONE = '{symbol_out: '0, last_out: 1'b0, done_res: 1'b1,
                                      overflow: 1'b0};
    localparam rtc_res_t OUT_NONE = '0;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                req_valid;
    logic                req_stall;
    rtc_req_t            req;
    logic                res_valid;
    logic                res_stall;
    rtc_res_t            res;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_index;
    logic [COL_W-1:0]    wr_data;

    // Cipher state as seen by the checker
    logic [SYM_W-1:0]    sym_mem [MAX_LEN];
    int unsigned         n_loaded;
    int unsigned         n_rows;
    int unsigned         route_pos;
    int unsigned         route_len;
    bit                  ovf_seen;
    bit                  msg_closed;
    logic [COL_W-1:0]    cfg_cols;
    logic                cfg_mode;
    int unsigned         key_cols;
    logic                key_mode;

    rtc_res_t            due_outputs [$];
    rtc_res_t            head_res;
    int unsigned         mismatch_count;
    int unsigned         items_sent;
    int unsigned         goal_items;
    int unsigned         cycle_count;
    int unsigned         send_idle_pct;
    int unsigned         stall_pct;

    script_row_t script [SCRIPT_LEN] = '{
        '{ROW_FETCH,    16'h0000, 1'b0, 1'b1, OUT_DONE},
        '{ROW_LOAD,     16'h0041, 1'b0, 1'b0, OUT_NONE},
        '{ROW_FETCH,    16'h0000, 1'b0, 1'b1, OUT_DONE},
        '{ROW_LOAD,     16'hffff, 1'b1, 1'b0, OUT_NONE},
        '{ROW_FETCH,    16'h0000, 1'b0, 1'b1, '{16'h0041, 1'b0, 1'b0, 1'b0}},
        '{ROW_FETCH,    16'h0000, 1'b0, 1'b1, '{16'hffff, 1'b1, 1'b0, 1'b0}},
        '{ROW_FETCH,    16'h0000, 1'b0, 1'b1, OUT_DONE},
        '{ROW_SET_COLS, 16'd3,    1'b0, 1'b0, OUT_NONE},
        '{ROW_SET_MODE, 16'd1,    1'b0, 1'b0, OUT_NONE},
        '{ROW_LOAD,     16'h0058, 1'b0, 1'b0, OUT_NONE},
        '{ROW_LOAD,     16'h0058, 1'b1, 1'b0, OUT_NONE},
        // every symbol stripped: first fetch already reports done
        '{ROW_FETCH,    16'h0000, 1'b0, 1'b1, OUT_DONE},
        '{ROW_SET_COLS, 16'd0,    1'b0, 1'b0, OUT_NONE},
        '{ROW_SET_MODE, 16'd0,    1'b0, 1'b0, OUT_NONE},
        '{ROW_LOAD,     16'h8000, 1'b0, 1'b0, OUT_NONE},
        '{ROW_LOAD,     16'h0001, 1'b1, 1'b0, OUT_NONE},
        // new key after close must not touch the message being read out
        '{ROW_SET_COLS, 16'd63,   1'b0, 1'b0, OUT_NONE},
        '{ROW_FETCH,    16'h0000, 1'b0, 1'b1, '{16'h8000, 1'b0, 1'b0, 1'b0}},
        '{ROW_FETCH,    16'h0000, 1'b0, 1'b1, '{16'h0001, 1'b1, 1'b0, 1'b0}},
        '{ROW_LOAD,     16'h7fff, 1'b1, 1'b0, OUT_NONE},
        '{ROW_FETCH,    16'h0000, 1'b0, 1'b0, OUT_NONE},
        '{ROW_FETCH,    16'h0000, 1'b0, 1'b0, OUT_NONE},
        '{ROW_SET_COLS, 16'd2,    1'b0, 1'b0, OUT_NONE},
        '{ROW_SET_MODE, 16'd1,    1'b0, 1'b0, OUT_NONE},
        '{ROW_LOAD,     16'h0041, 1'b0, 1'b0, OUT_NONE},
        '{ROW_LOAD,     16'h0042, 1'b0, 1'b0, OUT_NONE},
        '{ROW_LOAD,     16'h0043, 1'b1, 1'b0, OUT_NONE},
        '{ROW_FETCH,    16'h0000, 1'b0, 1'b0, OUT_NONE},
        '{ROW_FETCH,    16'h0000, 1'b0, 1'b0, OUT_NONE},
        '{ROW_FETCH,    16'h0000, 1'b0, 1'b0, OUT_NONE},
        '{ROW_FETCH,    16'h0000, 1'b0, 1'b0, OUT_NONE},
        '{ROW_FETCH,    16'h0000, 1'b0, 1'b0, OUT_NONE}
    };

    route_transposition_cipher_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Symbol at output position p of the latched key and mode
    function automatic logic [SYM_W-1:0] route_sym(int unsigned p);
        int unsigned idx;
        if (n_rows == 0)
            return PAD_SYMBOL;
        if (key_mode == MODE_ENCRYPT)
            idx = (p % n_rows) * key_cols + (key_cols - 1 - p / n_rows);
        else
            idx = (key_cols - 1 - p % key_cols) * n_rows + p / key_cols;
        return (idx < n_loaded) ? sym_mem[idx] : PAD_SYMBOL;
    endfunction

    function automatic void cipher_load(logic [SYM_W-1:0] sym, logic last);
        if (msg_closed)
        begin
            msg_closed = 1'b0;
            n_loaded   = 0;
            n_rows     = 0;
            route_pos  = 0;
            route_len  = 0;
            ovf_seen   = 1'b0;
        end
        if (n_loaded < MAX_LEN)
        begin
            sym_mem[n_loaded] = sym;
            n_loaded++;
        end
        else
            ovf_seen = 1'b1;
        if (last)
        begin
            // latch the key and size the table
            key_cols = (cfg_cols == 0) ? 1 : (cfg_cols > COL_LIMIT) ? COL_LIMIT : cfg_cols;
            key_mode = cfg_mode;
            n_rows   = (n_loaded + key_cols - 1) / key_cols;
            route_len = n_rows * key_cols;
            if (key_mode == MODE_DECRYPT)
                while (route_len > 0 && route_sym(route_len - 1) == PAD_SYMBOL)
                    route_len--;
            route_pos  = 0;
            msg_closed = 1'b1;
        end
    endfunction

    function automatic rtc_res_t cipher_fetch();
        rtc_res_t r;
        r = '0;
        r.overflow = ovf_seen;
        if (!msg_closed || route_pos >= route_len)
            r.done_res = 1'b1;
        else
        begin
            r.symbol_out = route_sym(route_pos);
            r.last_out   = (route_pos + 1 == route_len);
            route_pos++;
        end
        return r;
    endfunction

    function automatic void flag_mismatch(string what, rtc_res_t want, rtc_res_t got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("%0t mismatch, %s: expected sym=%h last=%b done=%b ovf=%b, %s",
                     $realtime, what, want.symbol_out, want.last_out, want.done_res,
                     want.overflow,
                     $sformatf("got sym=%h last=%b done=%b ovf=%b",
                               got.symbol_out, got.last_out, got.done_res, got.overflow));
    endfunction

    function automatic logic [COL_W-1:0] pick_columns();
        logic [COL_W-1:0] extremes [5] = '{6'd0, 6'd1, 6'd50, 6'd51, 6'd63};
        if ($urandom_range(0, 4) == 0)
            return extremes[$urandom_range(0, 4)];
        return COL_W'($urandom_range(1, COL_LIMIT));
    endfunction

    // Hand one item to the block, then update the prediction once it is taken
    task automatic send_item(logic rtype, logic [SYM_W-1:0] sym, logic last, bit typed,
                             rtc_res_t want);
        rtc_req_t item;
        rtc_res_t guess;
        item.req_type  = rtype;
        item.symbol_in = sym;
        item.last_in   = last;
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        do
            @(posedge clk);
        while (req_stall);
        items_sent++;
        if (rtype == REQ_LOAD)
            cipher_load(sym, last);
        else
        begin
            guess = cipher_fetch();
            due_outputs.push_back(typed ? want : guess);
        end
    endtask

    task automatic send_loads(int unsigned count, bit close, int unsigned pad_pct);
        logic [SYM_W-1:0] sym;
        for (int unsigned k = 0; k < count; k++)
        begin
            sym = ($urandom_range(0, 99) < pad_pct) ? PAD_SYMBOL : SYM_W'($urandom);
            send_item(REQ_LOAD, sym, close && (k == count - 1), 1'b0, OUT_NONE);
        end
    endtask

    task automatic send_fetches(int unsigned count);
        repeat (count)
            send_item(REQ_FETCH, SYM_W'($urandom), 1'($urandom), 1'b0, OUT_NONE);
    endtask

    // Drain outstanding results and let any closing pass finish
    task automatic settle_idle();
        req_valid <= 1'b0;
        while (due_outputs.size() != 0)
            @(posedge clk);
        repeat (POS_W + 8 + 2 * n_rows * key_cols) @(posedge clk);
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [COL_W-1:0] data);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        @(posedge clk);
        wr_en <= 1'b0;
        if (idx == CFG_COLUMNS)
            cfg_cols = data;
        else
            cfg_mode = data[0];
        @(posedge clk);
    endtask

    task automatic random_message();
        int unsigned len;
        int unsigned split;
        int unsigned style;
        int unsigned pad_pct;
        if ($urandom_range(0, 3) == 0)
        begin
            settle_idle();
            write_reg(CFG_COLUMNS, pick_columns());
            if ($urandom_range(0, 1) == 1)
                write_reg(CFG_MODE, COL_W'($urandom_range(0, 1)));
        end
        len     = ($urandom_range(0, 9) == 0) ? $urandom_range(61, 200) : $urandom_range(1, 40);
        pad_pct = ($urandom_range(0, 19) == 0) ? 100 : 25;
        style   = $urandom_range(0, 99);
        if (style < 10)
        begin
            // fetch in the middle of loading
            split = $urandom_range(0, len - 1);
            send_loads(split, 1'b0, pad_pct);
            send_fetches($urandom_range(1, 2));
            send_loads(len - split, 1'b1, pad_pct);
        end
        else
            send_loads(len, 1'b1, pad_pct);
        if ($urandom_range(0, 5) == 0)
        begin
            settle_idle();
            write_reg(CFG_COLUMNS, pick_columns());
            write_reg(CFG_MODE, COL_W'($urandom_range(0, 1)));
        end
        // abandon part of the output now and then; otherwise read to the end, sometimes past it
        if (style >= 10 && style < 20)
            send_fetches($urandom_range(0, route_len));
        else
            send_fetches(route_len + $urandom_range(0, 2));
    endtask

    always @(posedge clk)
        res_stall <= ($urandom_range(0, 99) < stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            if (due_outputs.size() == 0)
                flag_mismatch("unexpected item", OUT_NONE, res);
            else
            begin
                head_res = due_outputs.pop_front();
                if (res.symbol_out !== head_res.symbol_out || res.last_out !== head_res.last_out
                    || res.done_res !== head_res.done_res || res.overflow !== head_res.overflow)
                    flag_mismatch("wrong field", head_res, res);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req       <= '0;
        wr_en     <= 1'b0;
        wr_index  <= CFG_COLUMNS;
        wr_data   <= '0;
        n_loaded   = 0;
        n_rows     = 0;
        route_pos  = 0;
        route_len  = 0;
        ovf_seen   = 1'b0;
        msg_closed = 1'b0;
        cfg_cols   = 1;
        cfg_mode   = MODE_ENCRYPT;
        key_cols   = 1;
        key_mode   = MODE_ENCRYPT;
        mismatch_count = 0;
        items_sent     = 0;
        goal_items     = 0;
        cycle_count    = 0;
        send_idle_pct  = 34;
        stall_pct      = 87;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[k])
        begin
            case (script[k].op)
                ROW_LOAD:
                    send_item(REQ_LOAD, script[k].value, script[k].last, 1'b0, OUT_NONE);
                ROW_FETCH:
                    send_item(REQ_FETCH, SYM_W'($urandom), 1'($urandom), script[k].typed,
                              script[k].want);
                ROW_SET_COLS:
                begin
                    settle_idle();
                    write_reg(CFG_COLUMNS, script[k].value[COL_W-1:0]);
                end
                default:
                begin
                    settle_idle();
                    write_reg(CFG_MODE, script[k].value[COL_W-1:0]);
                end
            endcase
        end

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 34 : (phase == 1) ? 87 : 0;
            stall_pct     = (phase == 0) ? 87 : (phase == 1) ? 34 : 0;
            if (phase == 2)
            begin
                // six past a full store, closed by a dropped symbol
                settle_idle();
                write_reg(CFG_COLUMNS, COL_W'(COL_LIMIT));
                write_reg(CFG_MODE, COL_W'(MODE_DECRYPT));
                send_loads(MAX_LEN + 6, 1'b1, 25);
                send_fetches(OVF_FETCHES);
            end
            goal_items = items_sent + PHASE_ITEMS;
            while (items_sent < goal_items)
                random_message();
        end

        req_valid <= 1'b0;
        stall_pct = 0;
        while (due_outputs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && due_outputs.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
